### rtl/core/isqrt_pkg.sv
// ----------------------------------------------------------------------------
// isqrt_pkg
// Shared constants and types for the pipelined integer square root.
// ----------------------------------------------------------------------------
package isqrt_pkg;

    localparam int ISQ_OPERAND_WIDTH   = 32;
    localparam int ISQ_ROOT_WIDTH      = 17;
    // root digits resolved in each pipeline stage
    localparam int ISQ_STEPS_PER_STAGE = 2;

    typedef struct packed {
        logic valid;
        logic neg;
    } t_isq_ctl;

endpackage

### rtl/core/integer_square_root.sv
// ----------------------------------------------------------------------------
// integer_square_root
// Floor of the square root of a signed operand, fully pipelined.
// ----------------------------------------------------------------------------
// A word is taken at every clock edge where start is high and busy is low;
// busy is high during reset and in the cycle after it, then stays low,
// so one word can enter every cycle. Each word gives exactly one root on
// o_root, marked by o_valid for one cycle. o_valid rises once the word has
// passed an input register, one pipeline stage per two root bits and an
// output register. Results come out in order and cannot be held off.
// A negative operand gives -1; a root wider than o_root keeps its low bits.
module integer_square_root
    import isqrt_pkg::*;
#(
    parameter int OPERAND_WIDTH = ISQ_OPERAND_WIDTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic signed [OPERAND_WIDTH-1:0] i_value,
    output logic                            o_valid,
    output logic signed [ISQ_ROOT_WIDTH-1:0] o_root
);

    localparam int RW   = (OPERAND_WIDTH + 1) / 2;
    localparam int OPW  = 2 * RW;
    localparam int NSTG = (RW + ISQ_STEPS_PER_STAGE - 1) / ISQ_STEPS_PER_STAGE;
    localparam int LAST = RW - ISQ_STEPS_PER_STAGE * (NSTG - 1);
    localparam int LAT  = NSTG + 2;

    logic                        r_busy;
    t_isq_ctl                    r_in_ctl;
    logic [OPW-1:0]              r_in_opnd;
    logic                        r_valid;
    logic [ISQ_ROOT_WIDTH-1:0]   r_root, n_root;
    logic [ISQ_ROOT_WIDTH-1:0]   w_root_fit;

    t_isq_ctl                    c_ctl  [NSTG+1];
    logic [RW+1:0]               c_rem  [NSTG+1];
    logic [RW-1:0]               c_root [NSTG+1];
    logic [OPW-1:0]              c_opnd [NSTG+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b1;
            r_in_ctl <= '0;
            r_valid  <= 1'b0;
        end else begin
            r_busy         <= 1'b0;
            r_in_ctl.valid <= start && !r_busy;
            r_in_ctl.neg   <= i_value[OPERAND_WIDTH-1];
            r_valid        <= c_ctl[NSTG].valid;
        end
        r_in_opnd <= OPW'($unsigned(i_value));
        r_root    <= n_root;
    end

    assign c_ctl[0]  = r_in_ctl;
    assign c_rem[0]  = '0;
    assign c_root[0] = '0;
    assign c_opnd[0] = r_in_opnd;

    for (genvar g = 0; g < NSTG; g++) begin : g_stage
        isqrt_stage #(
            .ROOT_W (RW),
            .NSTEP  ((g == NSTG - 1) ? LAST : ISQ_STEPS_PER_STAGE)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (c_ctl[g]),
            .i_rem   (c_rem[g]),
            .i_root  (c_root[g]),
            .i_opnd  (c_opnd[g]),
            .o_ctl   (c_ctl[g+1]),
            .o_rem   (c_rem[g+1]),
            .o_root  (c_root[g+1]),
            .o_opnd  (c_opnd[g+1])
        );
    end

    // fit the root to the result width, wrapping when it is wider
    if (RW >= ISQ_ROOT_WIDTH) begin : g_trunc
        assign w_root_fit = c_root[NSTG][ISQ_ROOT_WIDTH-1:0];
    end else begin : g_extend
        assign w_root_fit = ISQ_ROOT_WIDTH'(c_root[NSTG]);
    end

    assign n_root = c_ctl[NSTG].neg ? '1 : w_root_fit;

    assign busy    = r_busy;
    assign o_valid = r_valid;
    assign o_root  = r_root;

    // every result traces back to a word taken earlier, through the input register, the stages and the output register
    a_result_has_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, LAT))
        else $error("result without a matching word");

    // a negative operand comes out as all ones
    a_negative_root: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && $past(i_value[OPERAND_WIDTH-1], LAT)) |-> (&o_root))
        else $error("negative operand did not give -1");

    // once out of reset the block never refuses a word
    a_busy_stays_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy |=> !busy)
        else $error("busy raised outside reset");

endmodule

### rtl/core/isqrt_stage.sv
// ----------------------------------------------------------------------------
// isqrt_stage
// One register stage of the digit-by-digit square root: resolves NSTEP root
// bits, two operand bits per root bit, and registers the partial state.
// ----------------------------------------------------------------------------
module isqrt_stage
    import isqrt_pkg::*;
#(
    parameter int ROOT_W = 16,
    parameter int NSTEP  = ISQ_STEPS_PER_STAGE
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_isq_ctl              i_ctl,
    input  logic [ROOT_W+1:0]     i_rem,
    input  logic [ROOT_W-1:0]     i_root,
    input  logic [2*ROOT_W-1:0]   i_opnd,
    output t_isq_ctl              o_ctl,
    output logic [ROOT_W+1:0]     o_rem,
    output logic [ROOT_W-1:0]     o_root,
    output logic [2*ROOT_W-1:0]   o_opnd
);

    t_isq_ctl              r_ctl;
    logic [ROOT_W+1:0]     r_rem, n_rem;
    logic [ROOT_W-1:0]     r_root, n_root;
    logic [2*ROOT_W-1:0]   r_opnd, n_opnd;

    always_comb begin
        logic [ROOT_W+1:0]   v_rem;
        logic [ROOT_W+1:0]   v_trial;
        logic [ROOT_W-1:0]   v_root;
        logic [2*ROOT_W-1:0] v_op;
        v_rem  = i_rem;
        v_root = i_root;
        v_op   = i_opnd;
        for (int k = 0; k < NSTEP; k++) begin
            // bring down the next pair of operand bits
            v_rem   = {v_rem[ROOT_W-1:0], v_op[2*ROOT_W-1 -: 2]};
            v_op    = v_op << 2;
            v_trial = {v_root, 2'b01};
            v_root  = v_root << 1;
            if (v_rem >= v_trial) begin
                v_rem     = v_rem - v_trial;
                v_root[0] = 1'b1;
            end
        end
        n_rem  = v_rem;
        n_root = v_root;
        n_opnd = v_op;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= i_ctl;
        end
        r_rem  <= n_rem;
        r_root <= n_root;
        r_opnd <= n_opnd;
    end

    assign o_ctl  = r_ctl;
    assign o_rem  = r_rem;
    assign o_root = r_root;
    assign o_opnd = r_opnd;

endmodule
